// ===== rtl/core/rws_pkg.sv =====
// Shared types and constants for the resampling wheel selector.
// Holds item structs, action and status codes, and the memory request struct.
// No dependencies.
package rws_pkg;

  // Sizing of the wheel.
  localparam int MAX_PARTICLES = 1024;
  localparam int WEIGHT_BITS   = 32;
  localparam int FRACTION_BITS = 16;

  // Derived widths.
  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int ACC_W  = WEIGHT_BITS + 2;
  localparam int INC_W  = WEIGHT_BITS + 1;
  localparam int STEP_W = CNT_W + 2;

  // Field widths of the item payloads.
  localparam int ACTION_W  = 2;
  localparam int WEIGHT_W  = 32;
  localparam int FRACTION_W = 16;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DRAW  = 2'd2;

  // Status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FLAG = 1'b1;

  // Reset value of the particle count register.
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1000);

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [IDX_W-1:0]      slot;
    logic [WEIGHT_W-1:0]   weight;
    logic [FRACTION_W-1:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] picked_index;
    logic             status;
  } out_item_t;

  // Access request from the controller to the weight memory.
  typedef struct packed {
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
  } ram_req_t;

endpackage

// ===== rtl/core/resampling_wheel_selector_unit.sv =====
// Top level of the resampling wheel selector.
// Depends on rws_pkg, rws_ram and rws_ctrl.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  rws_pkg::in_item_t
//   out_     output     out_valid/out_stall rws_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready particle count, 11 bits
//
// Load and start items are handled in the idle state. A draw walks the weights with
// one memory read per step on the single read port of the weight memory. A draw
// with a zero peak weight is flagged without a memory read.
// Synchronous reset clears the wheel state and sets the count to 1000; the
// weight memory is not cleared. A stalled output holds the finished draw and
// the next draw waits at its end; no further item is taken meanwhile.
module resampling_wheel_selector_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rws_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rws_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rws_pkg::CNT_W-1:0]   cfg_data
);
  import rws_pkg::*;

  logic [CNT_W-1:0]       cfg_count_r;
  logic [CNT_W-1:0]       live_count;
  ram_req_t               ram_req;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic                   res_valid;
  out_item_t              res;
  logic                   res_take;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= COUNT_RESET;
    end else if (cfg_valid) begin
      cfg_count_r <= cfg_data;
    end
  end

  // Count in use: zero counts as one, large values saturate.
  always_comb begin
    if (cfg_count_r == '0) begin
      live_count = CNT_W'(1);
    end else if (cfg_count_r > CNT_W'(MAX_PARTICLES)) begin
      live_count = CNT_W'(MAX_PARTICLES);
    end else begin
      live_count = cfg_count_r;
    end
  end

  // Weight memory.
  rws_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_PARTICLES)
  ) u_weights (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rdata)
  );

  // Wheel controller.
  rws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .count     (live_count),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: takes a result when empty or being drained.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/rws_ram.sv =====
// Generic single-write, single-read synchronous memory.
// Read data is registered and holds while no read is issued.
// No dependencies.
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rws_ctrl.sv =====
// Wheel controller: handles load, start and draw items, walks the weight memory.
// Depends on rws_pkg; drives the weight memory through a ram_req_t.
module rws_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rws_pkg::in_item_t               in_item,
  input  logic [rws_pkg::CNT_W-1:0]       count,
  output rws_pkg::ram_req_t               ram_req,
  input  logic [rws_pkg::WEIGHT_BITS-1:0] ram_rdata,
  output logic                            res_valid,
  output rws_pkg::out_item_t              res,
  input  logic                            res_take
);
  import rws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       wheel_idx_r, wheel_idx_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [WEIGHT_BITS-1:0] max_r, max_nxt;
  logic                   fresh_r, fresh_nxt;
  logic [INC_W-1:0]       inc_r, inc_nxt;
  logic [STEP_W-1:0]      steps_r, steps_nxt;
  logic                   status_r, status_nxt;

  logic                                 accept;
  logic [FRACTION_BITS-1:0]             frac;
  logic [WEIGHT_BITS-1:0]               load_w;
  logic [CNT_W-1:0]                     cnt_m1;
  logic [FRACTION_BITS+CNT_W-1:0]       start_prod;
  logic [FRACTION_BITS+INC_W-1:0]       draw_prod;
  logic [IDX_W-1:0]                     idx_first;
  logic [ACC_W-1:0]                     beta_sum;
  logic [ACC_W-1:0]                     rdata_ext;
  logic                                 beta_gt;
  logic [CNT_W-1:0]                     idx_inc;
  logic [IDX_W-1:0]                     idx_wrap;
  logic [STEP_W-1:0]                    limit;

  // Handshake: one item at a time, taken only when idle.
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // Operand extraction from the item.
  assign frac   = in_item.random_fraction[FRACTION_BITS-1:0];
  assign load_w = in_item.weight[WEIGHT_BITS-1:0];

  // Start position: floor(u * (count - 1)).
  assign cnt_m1     = count - CNT_W'(1);
  assign start_prod = {{CNT_W{1'b0}}, frac} * {{FRACTION_BITS{1'b0}}, cnt_m1};

  // Draw increment: floor(u * 2 * max), registered before the add.
  assign draw_prod = {{INC_W{1'b0}}, frac} * {{FRACTION_BITS{1'b0}}, max_r, 1'b0};

  // A stale index past the count restarts the walk at slot zero.
  assign idx_first = ({1'b0, wheel_idx_r} >= count) ? '0 : wheel_idx_r;

  // Walk datapath: the accumulator holds beta while walking.
  assign beta_sum  = acc_r + {1'b0, inc_r};
  assign rdata_ext = {2'b00, ram_rdata};
  assign beta_gt   = acc_r > rdata_ext;
  assign idx_inc   = {1'b0, wheel_idx_r} + CNT_W'(1);
  assign idx_wrap  = (idx_inc >= count) ? '0 : idx_inc[IDX_W-1:0];
  assign limit     = {count, 2'b00};

  // Result presented while in the done state.
  assign res_valid        = (state_r == S_DONE);
  assign res.picked_index = wheel_idx_r;
  assign res.status       = status_r;

  // Next-state and memory request logic.
  always_comb begin
    state_nxt     = state_r;
    wheel_idx_nxt = wheel_idx_r;
    acc_nxt       = acc_r;
    max_nxt       = max_r;
    fresh_nxt     = fresh_r;
    inc_nxt       = inc_r;
    steps_nxt     = steps_r;
    status_nxt    = status_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = in_item.slot;
    ram_req.wr_data = load_w;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = wheel_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_LOAD: begin
              ram_req.wr_en = 1'b1;
              if (fresh_r || (load_w > max_r)) begin
                max_nxt = load_w;
              end
              fresh_nxt = 1'b0;
            end
            ACT_START: begin
              wheel_idx_nxt = start_prod[FRACTION_BITS +: IDX_W];
              acc_nxt       = '0;
              fresh_nxt     = 1'b1;
            end
            ACT_DRAW: begin
              fresh_nxt     = 1'b1;
              wheel_idx_nxt = idx_first;
              if (max_r == '0) begin
                status_nxt = STAT_FLAG;
                state_nxt  = S_DONE;
              end else begin
                inc_nxt         = draw_prod[FRACTION_BITS +: INC_W];
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_first;
                steps_nxt       = '0;
                status_nxt      = STAT_OK;
                state_nxt       = S_ADD;
              end
            end
            default: begin
              // Unused action code: no effect.
            end
          endcase
        end
      end
      S_ADD: begin
        acc_nxt   = beta_sum;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (beta_gt) begin
          if (steps_r >= limit) begin
            status_nxt = STAT_FLAG;
            state_nxt  = S_DONE;
          end else begin
            acc_nxt         = acc_r - rdata_ext;
            wheel_idx_nxt   = idx_wrap;
            steps_nxt       = steps_r + STEP_W'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_wrap;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and wheel registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_idx_r <= '0;
      acc_r       <= '0;
      max_r       <= '0;
      fresh_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      wheel_idx_r <= wheel_idx_nxt;
      acc_r       <= acc_nxt;
      max_r       <= max_nxt;
      fresh_r     <= fresh_nxt;
    end
    inc_r    <= inc_nxt;
    steps_r  <= steps_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== rtl/core/rws_checker.sv =====
// Port-level checks for the resampling wheel selector.
// Depends on rws_pkg; bound to resampling_wheel_selector_unit below.
module rws_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input rws_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input rws_pkg::out_item_t out_item
);
  import rws_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A stalled item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // A draw always occupies the block past its accept cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.action == ACT_DRAW) |=> in_stall)
    else $error("draw did not hold off the next item");

  // Loads and starts never produce a result.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.action != ACT_DRAW) |=> !$rose(out_valid))
    else $error("result appeared after a non-draw item");

  // A result never appears in the cycle right after a draw is taken.
  a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.action == ACT_DRAW) |=> !$rose(out_valid))
    else $error("draw result appeared too early");

endmodule

bind resampling_wheel_selector_unit rws_checker u_rws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== tb/sv/resampling_wheel_selector_unit_test.sv =====
// Self-checking testbench for the resampling wheel selector: directed and random items,
// with the expected picks computed by a behavioral predictor of the wheel.
// Depends on rws_pkg and resampling_wheel_selector_unit.
module resampling_wheel_selector_unit_test;
  import rws_pkg::*;

  // Action code that the block ignores.
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
  localparam int PHASES = 24;
  localparam int PHASE_ITEMS = 42;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Predicted state of the wheel.
  logic [WEIGHT_BITS-1:0] weight_mem [MAX_PARTICLES];
  logic [WEIGHT_BITS-1:0] peak_weight = '0;
  int unsigned wheel_pos = 0;
  logic [ACC_W-1:0] wheel_acc = '0;
  logic restart_peak = 1'b1;
  logic [CNT_W-1:0] count_reg = COUNT_RESET;

  // Stimulus and checking bookkeeping.
  in_item_t pending_items[$];
  out_item_t expected_picks[$];
  bit slot_loaded [MAX_PARTICLES];
  int send_idle_pct = 37;
  int recv_idle_pct = 78;
  longint allowance = 0;
  longint cycle_count = 0;
  int items_queued = 0;
  int filler_loads = 0;
  int items_accepted = 0;
  int draws_checked = 0;
  int flagged_draws = 0;
  int mismatches = 0;
  int settings_written = 0;

  resampling_wheel_selector_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Number of slots actually on the wheel for a register value.
  function automatic int unsigned live_of(logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_PARTICLES) return MAX_PARTICLES;
    return 32'(c);
  endfunction

  // Apply one accepted item to the predicted wheel and queue its pick, if any.
  function automatic void advance_wheel(in_item_t it);
    int unsigned live;
    int unsigned steps;
    logic [63:0] prod;
    logic [ACC_W-1:0] beta;
    out_item_t pick;
    live = live_of(count_reg);
    case (it.action)
      ACT_LOAD: begin
        weight_mem[it.slot] = it.weight;
        if (restart_peak || it.weight > peak_weight) peak_weight = it.weight;
        restart_peak = 1'b0;
      end
      ACT_START: begin
        prod = 64'(it.random_fraction) * 64'(live - 1);
        wheel_pos = 32'(prod >> FRACTION_BITS);
        wheel_acc = '0;
        restart_peak = 1'b1;
      end
      ACT_DRAW: begin
        restart_peak = 1'b1;
        pick.status = STAT_OK;
        if (wheel_pos >= live) wheel_pos = 0;
        if (peak_weight == 0) begin
          pick.status = STAT_FLAG;
        end else begin
          // The increment is the fraction times twice the peak weight, truncated.
          prod = (64'(it.random_fraction) * {31'b0, peak_weight, 1'b0}) >> FRACTION_BITS;
          beta = ACC_W'(64'(wheel_acc) + prod);
          steps = 0;
          while (beta > weight_mem[wheel_pos]) begin
            if (steps >= 4 * live) begin
              pick.status = STAT_FLAG;
              break;
            end
            beta -= weight_mem[wheel_pos];
            wheel_pos = (wheel_pos + 1 >= live) ? 0 : wheel_pos + 1;
            steps++;
          end
          wheel_acc = beta;
        end
        pick.picked_index = IDX_W'(wheel_pos);
        expected_picks.insert(expected_picks.size(), pick);
      end
      default: begin
      end
    endcase
  endfunction

  // Compare one result item with the oldest expected pick.
  function automatic void check_pick(out_item_t got);
    out_item_t want;
    if (expected_picks.size() == 0) begin
      $error("unexpected result item: picked_index %0d status %0d",
             got.picked_index, got.status);
      mismatches++;
      return;
    end
    want = expected_picks.pop_front();
    draws_checked++;
    if (got.status == STAT_FLAG) flagged_draws++;
    if (got.picked_index !== want.picked_index) begin
      $error("picked_index: expected %0d, actual %0d", want.picked_index, got.picked_index);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatches++;
    end
  endfunction

  // Driver: present the oldest pending item and hold it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_wheel(in_item);
        void'(pending_items.pop_front());
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result item and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_pick(out_item);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog sized from the stimulus queued so far.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > 4 * allowance + 20000) begin
      $display("resampling_wheel_selector_unit_test NOT OK");
      $finish;
    end
  end

  function automatic void queue_item(logic [ACTION_W-1:0] act, int unsigned slot,
                                     logic [WEIGHT_W-1:0] w, logic [FRACTION_W-1:0] u);
    in_item_t it;
    it.action = act;
    it.slot = IDX_W'(slot);
    it.weight = w;
    it.random_fraction = u;
    pending_items.insert(pending_items.size(), it);
    allowance += 40;
    if (act == ACT_DRAW) allowance += 4 * live_of(count_reg) + 8;
    if (act == ACT_LOAD) slot_loaded[slot % MAX_PARTICLES] = 1'b1;
    if (act != ACT_IGNORED) items_queued++;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(int style);
    case (style)
      0: return '0;
      1: return $urandom_range(0, 7);
      2: return $urandom_range(0, 1000);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FRACTION_W-1:0] pick_fraction();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return FRACTION_W'($urandom_range(0, 65535));
  endfunction

  // A walk may visit any slot on the wheel, so each of them must hold a weight.
  function automatic void ensure_loaded();
    int unsigned live;
    live = live_of(count_reg);
    for (int unsigned s = 0; s < live; s++) begin
      if (!slot_loaded[s]) begin
        queue_item(ACT_LOAD, s, pick_weight(5), FRACTION_W'($urandom));
        filler_loads++;
      end
    end
  endfunction

  function automatic void queue_draw(logic [FRACTION_W-1:0] u);
    ensure_loaded();
    queue_item(ACT_DRAW, $urandom_range(0, 1023), $urandom, u);
  endfunction

  // Well-formed round: load the wheel, start it, then draw a few indexes.
  // Large wheels get only a handful of fresh weights per round.
  function automatic void wheel_round();
    int unsigned live, loads, rot;
    int style;
    live = live_of(count_reg);
    style = $urandom_range(0, 9);
    rot = $urandom_range(0, live - 1);
    loads = (live > 64) ? $urandom_range(1, 12) : live;
    for (int unsigned i = 0; i < loads; i++) begin
      if (live > 64) queue_item(ACT_LOAD, $urandom_range(0, live - 1), pick_weight(style),
                                FRACTION_W'($urandom));
      else queue_item(ACT_LOAD, (rot + i) % live, pick_weight(style), FRACTION_W'($urandom));
    end
    queue_item(ACT_START, $urandom_range(0, 1023), $urandom, pick_fraction());
    repeat ($urandom_range(1, 6)) queue_draw(pick_fraction());
  endfunction

  // Noise: any action with random fields, loads to any slot.
  function automatic void noise_burst();
    logic [ACTION_W-1:0] act;
    repeat ($urandom_range(1, 4)) begin
      act = ACTION_W'($urandom_range(0, 3));
      case (act)
        ACT_LOAD: queue_item(ACT_LOAD, $urandom_range(0, 1023),
                             pick_weight($urandom_range(0, 9)), FRACTION_W'($urandom));
        ACT_START: queue_item(ACT_START, $urandom_range(0, 1023), $urandom, pick_fraction());
        ACT_DRAW: queue_draw(pick_fraction());
        default: queue_item(ACT_IGNORED, $urandom_range(0, 1023), $urandom,
                            FRACTION_W'($urandom));
      endcase
    end
  endfunction

  // Broken round: partial reloads and draws with no start in between.
  function automatic void broken_sequence();
    int unsigned live;
    live = live_of(count_reg);
    repeat ($urandom_range(1, 3))
      queue_item(ACT_LOAD, $urandom_range(0, live - 1), pick_weight($urandom_range(0, 9)),
                 FRACTION_W'($urandom));
    repeat ($urandom_range(1, 3)) queue_draw(pick_fraction());
    if ($urandom_range(0, 1)) queue_item(ACT_START, $urandom_range(0, 1023), $urandom,
                                         pick_fraction());
  endfunction

  function automatic int pick_count(int p);
    int roll;
    if (p == 1) return 2047;
    if (p == PHASES / 3 + 1) return MAX_PARTICLES;
    if (p == 2 * PHASES / 3 + 1) return 1;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(1, 16);
    if (roll < 9) return $urandom_range(17, 64);
    return $urandom_range(65, 1023);
  endfunction

  // Wait until every pending item is accepted and every pick has come back.
  task automatic drain();
    while (pending_items.size() != 0 || expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the particle count while the block is idle.
  task automatic write_particle_count(int value);
    allowance += 200;
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    count_reg = CNT_W'(value);
    settings_written++;
  endtask

  initial begin
    int goal;
    int roll;
    allowance = 1000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero peak weight right after reset, a start at the top fraction, ignored action.
    queue_item(ACT_DRAW, 0, '0, '1);
    queue_item(ACT_START, 0, '0, '1);
    queue_item(ACT_DRAW, 0, '0, '0);
    queue_item(ACT_IGNORED, 1023, '1, '1);
    drain();

    // Small wheel: the index left by the start lies past the count, extreme weights.
    write_particle_count(4);
    queue_item(ACT_LOAD, 1023, '0, '0);
    queue_item(ACT_LOAD, 0, 32'hFFFF_FFFF, '0);
    queue_item(ACT_LOAD, 1, '0, '0);
    queue_item(ACT_LOAD, 2, 32'd1, '0);
    queue_item(ACT_LOAD, 3, 32'h8000_0000, '0);
    queue_item(ACT_DRAW, 0, '0, 16'h8000);
    queue_item(ACT_START, 0, '0, '0);
    queue_item(ACT_LOAD, 2, 32'd5, '0);
    queue_item(ACT_DRAW, 0, '0, '1);
    queue_item(ACT_DRAW, 0, '0, '1);
    drain();

    // Zero weights on the wheel with a nonzero peak: the walk hits its step limit.
    write_particle_count(2);
    queue_item(ACT_LOAD, 0, '0, '0);
    queue_item(ACT_LOAD, 1, '0, '0);
    queue_item(ACT_LOAD, 512, 32'd7, '0);
    queue_item(ACT_DRAW, 0, '0, '1);
    queue_item(ACT_DRAW, 0, '0, '1);
    drain();

    // A count of zero acts as a one-slot wheel; then a zero peak after a reload.
    write_particle_count(0);
    queue_item(ACT_LOAD, 0, 32'd5, '0);
    queue_item(ACT_START, 0, '0, '1);
    queue_item(ACT_DRAW, 0, '0, '1);
    queue_item(ACT_LOAD, 0, '0, '0);
    queue_item(ACT_DRAW, 0, '0, '1);

    // Random phases, each under its own particle count; the stall pattern changes twice.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == PHASES / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 37;
      end
      if (p == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_particle_count(pick_count(p));
      goal = items_queued - filler_loads + PHASE_ITEMS;
      while (items_queued - filler_loads < goal) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) wheel_round();
        else if (roll < 85) noise_burst();
        else broken_sequence();
      end
    end

    drain();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d items and %0d checked draws (%0d flagged),",
             items_accepted, draws_checked, flagged_draws);
    $display("over %0d particle-count settings and three stall patterns.", settings_written);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("resampling_wheel_selector_unit_test OK");
    end else begin
      $display("resampling_wheel_selector_unit_test NOT OK");
    end
    $finish;
  end

endmodule
